>>> rtl/core/superpixel_pooling_labeler_defines.svh
// Assertion macros shared by the superpixel pooling labeler RTL.
`ifndef SUPERPIXEL_POOLING_LABELER_DEFINES_SVH
`define SUPERPIXEL_POOLING_LABELER_DEFINES_SVH
`ifndef SYNTH
// Checks a property under reset gating.
`define SPL_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("superpixel pooling labeler check failed");
// Checks a property at every edge, reset included.
`define SPL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("superpixel pooling labeler check failed");
`else
`define SPL_ASSERT(lbl, clk, rstn, prop)
`define SPL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> rtl/core/spl_pkg.sv
// Package with shared types and constants of the superpixel pooling labeler.
package spl_pkg;
    localparam int SP_W      = 8;
    localparam int CH_W      = 6;
    localparam int CELL_AW   = SP_W + CH_W;
    localparam int NCH_W     = 7;
    localparam int CNT_W     = 17;
    localparam int SAL_W     = 25;
    localparam int CLS_W     = 8;
    localparam int ACC_W     = 32;
    localparam int AM_W      = 17;
    localparam int NUM_W     = 34;
    localparam int DEN_W     = 18;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic CFG_POOL_MODE = 1'b0;
    localparam logic CFG_CHANNELS  = 1'b1;

    localparam logic [NCH_W-1:0] MAX_CH = 7'd64;
    localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [SAL_W-1:0] SAL_MAX = 25'h1FFFFFF;
    localparam logic [8:0] SAL_CAP = 9'd256;
    localparam logic [CLS_W-1:0] CLASS_FG_MAX = 8'd20;

    localparam logic [7:0] LABEL_BG  = 8'd0;
    localparam logic [7:0] LABEL_FG  = 8'd1;
    localparam logic [7:0] LABEL_IGN = 8'd255;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SAL_W-1:0] sal_sum;
        logic [CLS_W-1:0] first_class;
        logic             seen;
    } sp_stat_t;

    typedef struct packed {
        logic             upd;
        logic [8:0]       saliency;
        logic [CLS_W-1:0] seg_class;
        logic             clr;
        logic [SP_W-1:0]  clr_addr;
    } sp_req_t;
endpackage

>>> rtl/core/spl_divider.sv
// Restoring divider, one quotient bit per cycle, for the rounded mean.
module spl_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [spl_pkg::NUM_W-1:0] num,
    input  logic [spl_pkg::DEN_W-1:0] den,
    output logic                      done,
    output logic [spl_pkg::NUM_W-1:0] quo
);
    import spl_pkg::*;

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next, den_reg;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             ge;

    always_comb begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = 6'(NUM_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

>>> rtl/core/spl_sp_stats.sv
// Per-superpixel statistics memory with its update and region label logic.
module spl_sp_stats (
    input  logic                     aclk,
    input  logic [spl_pkg::SP_W-1:0] rd_addr,
    input  spl_pkg::sp_req_t         req,
    output spl_pkg::sp_stat_t        stat,
    output logic [7:0]               region_label
);
    import spl_pkg::*;

    sp_stat_t mem [0:(1 << SP_W)-1];
    sp_stat_t rdata_reg;
    sp_stat_t wdata;
    logic [8:0]       sal_c;
    logic [SAL_W:0]   sal_add;
    logic [27:0]      sal_x5;
    logic [28:0]      sal_x10;
    logic [7:0]       lab;

    always_comb begin
        sal_c   = (req.saliency > SAL_CAP) ? SAL_CAP : req.saliency;
        sal_add = {1'b0, rdata_reg.sal_sum} + {17'd0, sal_c};
        wdata   = rdata_reg;
        if (rdata_reg.count != COUNT_MAX) begin
            wdata.count = rdata_reg.count + 17'd1;
        end
        wdata.sal_sum = sal_add[SAL_W] ? SAL_MAX : sal_add[SAL_W-1:0];
        if (!rdata_reg.seen) begin
            wdata.first_class = req.seg_class;
            wdata.seen        = 1'b1;
        end
    end

    // Update writes back to the entry whose read data is presented this cycle.
    always_ff @(posedge aclk) begin
        if (req.clr) begin
            mem[req.clr_addr] <= '0;
        end else if (req.upd) begin
            mem[rd_addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[rd_addr];
    end

    // Mean saliency compared as rationals: above 0.8 and above 0.1.
    always_comb begin
        sal_x5  = {3'd0, rdata_reg.sal_sum} * 28'd5;
        sal_x10 = {4'd0, rdata_reg.sal_sum} * 29'd10;
        lab     = LABEL_BG;
        if (rdata_reg.count != '0) begin
            if (sal_x5 > {1'b0, rdata_reg.count, 10'd0}) begin
                lab = LABEL_FG;
            end else if (sal_x10 > {4'd0, rdata_reg.count, 8'd0}) begin
                lab = LABEL_IGN;
            end
        end
        if (rdata_reg.seen) begin
            if (rdata_reg.first_class >= 8'd1 && rdata_reg.first_class <= CLASS_FG_MAX) begin
                lab = LABEL_FG;
            end else if (rdata_reg.first_class == '0) begin
                lab = LABEL_BG;
            end
        end
    end

    assign stat         = rdata_reg;
    assign region_label = lab;
endmodule

>>> rtl/core/superpixel_pooling_labeler.sv
// Top level of the superpixel pooling labeler: control, cell memory, output stage.
//
// Input channel (s_*): one request per item. Action sample updates the cell of
// (superpixel, channel) and, on channel 0, the superpixel's count, saliency sum
// and first class. Action read emits one result per channel in use on the m_*
// channel, m_last marking the final channel. Action clear reinitializes all
// accumulators for the current pool mode.
// Sequencing: a sample reads the memories, then modifies and writes back.
// A read steps through each channel in use: memory read, evaluation, then,
// in average mode for a non-empty superpixel, the 34-step bit-serial divider
// that forms the rounded mean, then output. A clear walks all 16384 cell
// memory entries, one entry per cycle.
// Reset runs the same clearing pass; s_ready stays low until it ends.
// Configuration writes are taken at any time through cfg_we.
// A stalled receiver holds the result in the output register; the readout
// waits for it before the next channel is presented.
`include "superpixel_pooling_labeler_defines.svh"
module superpixel_pooling_labeler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic signed [8:0]  s_superpixel,
    input  logic [5:0]  s_channel,
    input  logic [15:0] s_pixel_index,
    input  logic signed [15:0] s_feature,
    input  logic [8:0]  s_saliency,
    input  logic [7:0]  s_seg_class,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_superpixel,
    output logic [5:0]  m_out_channel,
    output logic signed [15:0] m_pooled,
    output logic signed [16:0] m_argmax_pixel,
    output logic [7:0]  m_region_label,
    output logic        m_empty_res,
    output logic        m_last
);
    import spl_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_UPD, S_EVAL, S_DIV, S_EMIT, S_RDWAIT
    } state_t;

    state_t state_reg, state_next;

    logic             pool_mode_reg;
    logic [NCH_W-1:0] chans_reg;
    logic [NCH_W-1:0] nch;

    logic [CELL_AW:0]   clr_cnt_reg, clr_cnt_next;
    logic               clr_mode_reg, clr_mode_next;
    logic [SP_W-1:0]    sp_reg, sp_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [15:0]        pix_reg, pix_next;
    logic signed [15:0] feat_reg, feat_next;
    logic [8:0]         sal_reg, sal_next;
    logic [7:0]         cls_reg, cls_next;

    logic [15:0]        res_pooled_reg, res_pooled_next;
    logic [AM_W-1:0]    res_am_reg, res_am_next;

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_sp_reg, m_sp_next;
    logic [5:0]  m_ch_reg, m_ch_next;
    logic [15:0] m_pooled_reg, m_pooled_next;
    logic [16:0] m_am_reg, m_am_next;
    logic [7:0]  m_lab_reg, m_lab_next;
    logic        m_empty_reg, m_empty_next;
    logic        m_last_reg, m_last_next;

    // Cell memory: accumulator and argmax per (superpixel, channel).
    logic [ACC_W+AM_W-1:0] cell_mem [0:(1 << CELL_AW)-1];
    logic [ACC_W+AM_W-1:0] cell_rdata_reg;
    logic [ACC_W+AM_W-1:0] cell_wdata;
    logic [CELL_AW-1:0]    cell_raddr, cell_waddr;
    logic                  cell_we;
    logic signed [ACC_W-1:0] acc;
    logic [AM_W-1:0]         am;
    logic signed [ACC_W:0]   acc_sum;

    logic [SP_W-1:0] sp_raddr;
    sp_req_t         sp_req;
    sp_stat_t        stat;
    logic [7:0]      region_lab;

    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num, div_quo;
    logic [ACC_W-1:0] mag;
    logic             accept;
    logic             out_free;

    always_comb begin
        nch = chans_reg;
        if (nch == '0) begin
            nch = 7'd1;
        end
        if (nch > MAX_CH) begin
            nch = MAX_CH;
        end
    end

    assign acc      = cell_rdata_reg[ACC_W+AM_W-1:AM_W];
    assign am       = cell_rdata_reg[AM_W-1:0];
    assign acc_sum  = {acc[ACC_W-1], acc} + (ACC_W+1)'(feat_reg);
    assign mag      = acc[ACC_W-1] ? (~acc + 32'd1) : acc;
    assign div_num  = {1'b0, mag, 1'b0} + {17'd0, stat.count};
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    assign sp_raddr   = (state_reg == S_IDLE) ? s_superpixel[SP_W-1:0] : sp_reg;
    assign cell_raddr = (state_reg == S_IDLE) ? {s_superpixel[SP_W-1:0], s_channel}
                                              : {sp_reg, ch_reg};

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_mode_next   = clr_mode_reg;
        sp_next         = sp_reg;
        ch_next         = ch_reg;
        pix_next        = pix_reg;
        feat_next       = feat_reg;
        sal_next        = sal_reg;
        cls_next        = cls_reg;
        res_pooled_next = res_pooled_reg;
        res_am_next     = res_am_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_sp_next       = m_sp_reg;
        m_ch_next       = m_ch_reg;
        m_pooled_next   = m_pooled_reg;
        m_am_next       = m_am_reg;
        m_lab_next      = m_lab_reg;
        m_empty_next    = m_empty_reg;
        m_last_next     = m_last_reg;
        cell_we         = 1'b0;
        cell_waddr      = {sp_reg, ch_reg};
        cell_wdata      = cell_rdata_reg;
        sp_req          = '0;
        sp_req.saliency  = sal_reg;
        sp_req.seg_class = cls_reg;
        sp_req.clr_addr  = clr_cnt_reg[SP_W-1:0];
        div_start       = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                cell_we    = 1'b1;
                cell_waddr = clr_cnt_reg[CELL_AW-1:0];
                cell_wdata = {clr_mode_reg ? 32'd0 : 32'h8000_0000, {AM_W{1'b1}}};
                sp_req.clr = (clr_cnt_reg[CELL_AW-1:SP_W] == '0);
                clr_cnt_next = clr_cnt_reg + 15'd1;
                if (clr_cnt_reg[CELL_AW-1:0] == {CELL_AW{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    sp_next   = s_superpixel[SP_W-1:0];
                    ch_next   = (s_action == ACT_READ) ? '0 : s_channel;
                    pix_next  = s_pixel_index;
                    feat_next = s_feature;
                    sal_next  = s_saliency;
                    cls_next  = s_seg_class;
                    if (s_action == ACT_CLEAR) begin
                        clr_mode_next = pool_mode_reg;
                        clr_cnt_next  = '0;
                        state_next    = S_CLEAR;
                    end else if (!s_superpixel[8]) begin
                        if (s_action == ACT_SAMPLE && {1'b0, s_channel} < nch) begin
                            state_next = S_UPD;
                        end else if (s_action == ACT_READ) begin
                            state_next = S_RDWAIT;
                        end
                    end
                end
            end
            S_UPD: begin
                cell_we = 1'b1;
                if (!pool_mode_reg) begin
                    if (ACC_W'(feat_reg) > acc) begin
                        cell_wdata = {ACC_W'(feat_reg), 1'b0, pix_reg};
                    end
                end else begin
                    if (acc_sum > 33'sh0_7FFF_FFFF) begin
                        cell_wdata[ACC_W+AM_W-1:AM_W] = 32'h7FFF_FFFF;
                    end else if (acc_sum < -33'sh0_8000_0000) begin
                        cell_wdata[ACC_W+AM_W-1:AM_W] = 32'h8000_0000;
                    end else begin
                        cell_wdata[ACC_W+AM_W-1:AM_W] = acc_sum[ACC_W-1:0];
                    end
                end
                sp_req.upd = (ch_reg == '0);
                state_next = S_IDLE;
            end
            S_RDWAIT: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                res_am_next = {AM_W{1'b1}};
                if (!pool_mode_reg) begin
                    if (!am[AM_W-1]) begin
                        res_am_next = am;
                        if (acc > 32'sd32767) begin
                            res_pooled_next = 16'h7FFF;
                        end else if (acc < -32'sd32768) begin
                            res_pooled_next = 16'h8000;
                        end else begin
                            res_pooled_next = acc[15:0];
                        end
                    end else begin
                        res_pooled_next = 16'h8000;
                    end
                    state_next = S_EMIT;
                end else if (stat.count == '0) begin
                    res_pooled_next = '0;
                    state_next      = S_EMIT;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (!acc[ACC_W-1]) begin
                        res_pooled_next = (div_quo > 34'd32767) ? 16'h7FFF : div_quo[15:0];
                    end else begin
                        res_pooled_next = (div_quo > 34'd32768) ? 16'h8000
                                                                 : 16'(~div_quo[15:0] + 16'd1);
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_sp_next     = sp_reg;
                    m_ch_next     = ch_reg;
                    m_pooled_next = res_pooled_reg;
                    m_am_next     = res_am_reg;
                    m_lab_next    = region_lab;
                    m_empty_next  = (stat.count == '0);
                    m_last_next   = ({1'b0, ch_reg} + 7'd1 == nch);
                    if ({1'b0, ch_reg} + 7'd1 == nch) begin
                        state_next = S_IDLE;
                    end else begin
                        ch_next    = ch_reg + 6'd1;
                        state_next = S_RDWAIT;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            clr_mode_reg  <= 1'b0;
            pool_mode_reg <= 1'b0;
            chans_reg     <= MAX_CH;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_mode_reg <= clr_mode_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_POOL_MODE: pool_mode_reg <= cfg_data[0];
                    CFG_CHANNELS:  chans_reg     <= cfg_data;
                    default:       chans_reg     <= chans_reg;
                endcase
            end
        end
        sp_reg         <= sp_next;
        ch_reg         <= ch_next;
        pix_reg        <= pix_next;
        feat_reg       <= feat_next;
        sal_reg        <= sal_next;
        cls_reg        <= cls_next;
        res_pooled_reg <= res_pooled_next;
        res_am_reg     <= res_am_next;
        m_sp_reg       <= m_sp_next;
        m_ch_reg       <= m_ch_next;
        m_pooled_reg   <= m_pooled_next;
        m_am_reg       <= m_am_next;
        m_lab_reg      <= m_lab_next;
        m_empty_reg    <= m_empty_next;
        m_last_reg     <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (cell_we) begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        cell_rdata_reg <= cell_mem[cell_raddr];
    end

    spl_sp_stats u_sp_stats (
        .aclk         (aclk),
        .rd_addr      (sp_raddr),
        .req          (sp_req),
        .stat         (stat),
        .region_label (region_lab)
    );

    spl_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     ({stat.count, 1'b0}),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign m_valid          = m_valid_reg;
    assign m_out_superpixel = m_sp_reg;
    assign m_out_channel    = m_ch_reg;
    assign m_pooled         = m_pooled_reg;
    assign m_argmax_pixel   = m_am_reg;
    assign m_region_label   = m_lab_reg;
    assign m_empty_res      = m_empty_reg;
    assign m_last           = m_last_reg;

    `SPL_ASSERT(a_div_only_in_div, aclk, aresetn, div_done |-> state_reg == S_DIV)
    `SPL_ASSERT(a_cell_write_ctx, aclk, aresetn,
                cell_we |-> (state_reg == S_UPD || state_reg == S_CLEAR))
    `SPL_ASSERT(a_emit_waits, aclk, aresetn,
                (state_reg == S_EMIT && m_valid_reg && !m_ready) |=> state_reg == S_EMIT)
endmodule
